[sv/nnb_pkg.sv]
// nnb_pkg: shared widths, register indexes and reset values for the
// nearest-neighbor blit address generator. No dependencies.
`timescale 1ns / 1ps

package nnb_pkg;

  localparam int DEF_MAX_DIMENSION = 4096;

  localparam int CFG_W     = 15;  // widest register
  localparam int CFG_ADR_W = 3;
  localparam int DIM_REG_W = 13;
  localparam int SPB_W     = 3;
  localparam int PITCH_W   = 15;
  localparam int IN_W      = 12;
  localparam int SRC_OFF_W = 26;
  localparam int DST_OFF_W = 28;

  typedef enum logic [CFG_ADR_W-1:0] {
    CFG_SOURCE_WIDTH       = 3'd0,
    CFG_SOURCE_HEIGHT      = 3'd1,
    CFG_TARGET_HEIGHT      = 3'd2,
    CFG_SOURCE_PIXEL_BYTES = 3'd3,
    CFG_SCREEN_WIDTH       = 3'd4,
    CFG_SCREEN_HEIGHT      = 3'd5,
    CFG_SCREEN_PITCH       = 3'd6,
    CFG_CENTER_MODE        = 3'd7
  } cfg_idx_t;

  localparam int RST_SOURCE_WIDTH       = 1;
  localparam int RST_SOURCE_HEIGHT      = 1;
  localparam int RST_TARGET_HEIGHT      = 1;
  localparam int RST_SOURCE_PIXEL_BYTES = 3;
  localparam int RST_SCREEN_WIDTH       = 1;
  localparam int RST_SCREEN_HEIGHT      = 1;
  localparam int RST_SCREEN_PITCH       = 4;
  localparam int RST_CENTER_MODE        = 0;

  localparam int RST_SCALED_WIDTH =
    RST_SOURCE_WIDTH * RST_TARGET_HEIGHT / RST_SOURCE_HEIGHT;
  localparam int RST_LIMIT = RST_SCREEN_PITCH * RST_SCREEN_HEIGHT;

endpackage

[sv/nnb_div_cell.sv]
// nnb_div_cell: one restoring-division step for two lanes (column and row)
// plus a carried tag word. Chained to form the per-pixel divider.
`timescale 1ns / 1ps

module nnb_div_cell #(
  parameter int DVW = 25,
  parameter int RW  = 27,
  parameter int TW  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [RW-1:0]  div_col,
  input  logic [RW-1:0]  div_row,
  input  logic           in_vld,
  input  logic [RW-1:0]  in_rem_col,
  input  logic [DVW-1:0] in_dq_col,
  input  logic [RW-1:0]  in_rem_row,
  input  logic [DVW-1:0] in_dq_row,
  input  logic [TW-1:0]  in_tag,
  output logic           out_vld,
  output logic [RW-1:0]  out_rem_col,
  output logic [DVW-1:0] out_dq_col,
  output logic [RW-1:0]  out_rem_row,
  output logic [DVW-1:0] out_dq_row,
  output logic [TW-1:0]  out_tag
);

  logic           vld_r;
  logic [RW-1:0]  rem_col_r, rem_col_nxt;
  logic [DVW-1:0] dq_col_r, dq_col_nxt;
  logic [RW-1:0]  rem_row_r, rem_row_nxt;
  logic [DVW-1:0] dq_row_r, dq_row_nxt;
  logic [TW-1:0]  tag_r;

  logic [RW-1:0]  try_col, try_row;
  logic           ge_col, ge_row;

  // dividend and quotient share one shift word: top bit out, quotient bit in
  always_comb begin
    try_col     = {in_rem_col[RW-2:0], in_dq_col[DVW-1]};
    ge_col      = (try_col >= div_col);
    rem_col_nxt = ge_col ? (try_col - div_col) : try_col;
    dq_col_nxt  = {in_dq_col[DVW-2:0], ge_col};

    try_row     = {in_rem_row[RW-2:0], in_dq_row[DVW-1]};
    ge_row      = (try_row >= div_row);
    rem_row_nxt = ge_row ? (try_row - div_row) : try_row;
    dq_row_nxt  = {in_dq_row[DVW-2:0], ge_row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_col_r <= rem_col_nxt;
    dq_col_r  <= dq_col_nxt;
    rem_row_r <= rem_row_nxt;
    dq_row_r  <= dq_row_nxt;
    tag_r     <= in_tag;
  end

  assign out_vld     = vld_r;
  assign out_rem_col = rem_col_r;
  assign out_dq_col  = dq_col_r;
  assign out_rem_row = rem_row_r;
  assign out_dq_row  = dq_row_r;
  assign out_tag     = tag_r;

endmodule

[sv/nnb_scale_calc.sv]
// nnb_scale_calc: recomputes the scaled width, the centering origin and the
// visibility limit after each register write. Uses nnb_pkg.
`timescale 1ns / 1ps

module nnb_scale_calc import nnb_pkg::*; #(
  parameter int DW   = 13,
  parameter int LIMW = 44
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 recalc,
  input  logic [DW-1:0]        sw,
  input  logic [DW-1:0]        sh,
  input  logic [DW-1:0]        th,
  input  logic [DW-1:0]        fw,
  input  logic [DW-1:0]        fh,
  input  logic [PITCH_W-1:0]   pitch,
  input  logic                 center,
  output logic                 busy,
  output logic [2*DW-1:0]      scaled_w,
  output logic signed [2*DW:0] ox,
  output logic signed [DW:0]   oy,
  output logic signed [LIMW-1:0] limit
);

  localparam int SWW = 2 * DW;
  localparam int OXW = SWW + 1;
  localparam int OYW = DW + 1;
  localparam int CW  = $clog2(SWW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } calc_state_t;

  calc_state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [SWW-1:0]        dq_r, dq_nxt;
  logic [DW-1:0]         rem_r, rem_nxt;
  logic [SWW-1:0]        scaled_r, scaled_nxt;
  logic signed [OXW-1:0] ox_r, ox_nxt;
  logic signed [OYW-1:0] oy_r, oy_nxt;
  logic signed [LIMW-1:0] limit_r, limit_nxt;

  logic [SWW-1:0]         prod_c;
  logic [DW:0]            step_c, rem_step;
  logic                   ge;
  logic signed [OXW-1:0]  dx, dx_adj, ox_c;
  logic signed [OYW-1:0]  dy, dy_adj, oy_c;
  logic [PITCH_W+DW-1:0]  lim_c;

  assign prod_c   = sw * th;
  assign step_c   = {rem_r, dq_r[SWW-1]};
  assign ge       = (step_c >= {1'b0, sh});
  assign rem_step = ge ? (step_c - {1'b0, sh}) : step_c;

  // halving that truncates toward zero
  assign dx     = $signed(OXW'(fw)) - $signed(OXW'(dq_r));
  assign dx_adj = dx + $signed({{(OXW-1){1'b0}}, dx[OXW-1]});
  assign ox_c   = dx_adj >>> 1;
  assign dy     = $signed(OYW'(fh)) - $signed(OYW'(th));
  assign dy_adj = dy + $signed({{(OYW-1){1'b0}}, dy[OYW-1]});
  assign oy_c   = dy_adj >>> 1;
  assign lim_c  = pitch * fh;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    scaled_nxt = scaled_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    limit_nxt  = limit_r;
    if (recalc) begin
      state_nxt = ST_MUL;
    end else begin
      case (state_r)
        ST_IDLE: begin
        end
        ST_MUL: begin
          dq_nxt    = prod_c;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
        ST_DIV: begin
          dq_nxt  = {dq_r[SWW-2:0], ge};
          rem_nxt = rem_step[DW-1:0];
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(SWW - 1)) begin
            state_nxt = ST_FIN;
          end
        end
        ST_FIN: begin
          scaled_nxt = dq_r;
          ox_nxt     = center ? ox_c : '0;
          oy_nxt     = center ? oy_c : '0;
          limit_nxt  = $signed(LIMW'(lim_c));
          state_nxt  = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      scaled_r <= SWW'(RST_SCALED_WIDTH);
      ox_r     <= '0;
      oy_r     <= '0;
      limit_r  <= LIMW'(RST_LIMIT);
    end else begin
      state_r  <= state_nxt;
      scaled_r <= scaled_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      limit_r  <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = (state_r != ST_IDLE);
  assign scaled_w = scaled_r;
  assign ox       = ox_r;
  assign oy       = oy_r;
  assign limit    = limit_r;

endmodule

[sv/nearest_neighbor_blit_address_gen.sv]
// nearest_neighbor_blit_address_gen: top level, register file, entry stage,
// divider cell chain and output stages. Uses nnb_pkg, nnb_div_cell and
// nnb_scale_calc.
//
// Usage: write registers through cfg_we/cfg_addr/cfg_wdata, one per clock.
// Each write starts a recompute of the scaled width, the centering origin
// and the visibility limit; busy stays high through its multiply, divide
// and finish states after the last write. A word (scan index, destination
// column) is taken at any edge where start is high and busy is low, one
// per clock when start is held. Each word gives one result word, strobed
// by out_valid for exactly one cycle, in order. Each word passes an entry
// stage, the divider chain, one cell per quotient bit (12+DW cells, DW
// being the bit width of MAX_DIMENSION), and two output stages.
// The receiver cannot stall; results are simply presented and dropped.
// Reset loads the register defaults, clears all valid flags and leaves
// busy low, so words may be sent right after reset.
`timescale 1ns / 1ps

module nearest_neighbor_blit_address_gen import nnb_pkg::*; #(
  parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_ADR_W-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]            cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic [IN_W-1:0]             in_scan_index,
  input  logic [IN_W-1:0]             in_dest_column,
  output logic                        out_valid,
  output logic [SRC_OFF_W-1:0]        out_source_offset,
  output logic signed [DST_OFF_W-1:0] out_dest_offset,
  output logic                        out_on_screen
);

  localparam int DW   = $clog2(MAX_DIMENSION + 1);
  localparam int PW   = IN_W + DW;        // dividend and quotient width
  localparam int SWW  = 2 * DW;           // scaled width
  localparam int RW   = SWW + 1;          // remainder
  localparam int OXW  = SWW + 1;
  localparam int OYW  = DW + 1;
  localparam int RPW  = DW + 14;          // destination row plus origin
  localparam int JXW  = SWW + 14;         // column plus origin
  localparam int TW   = RPW + JXW;
  localparam int MPW  = RPW + DW + 1;
  localparam int DSW  = 2 * DW + 18;      // exact destination offset
  localparam int LAT  = PW + 3;

  // registers
  logic [DIM_REG_W-1:0] src_w_r, src_h_r, tgt_h_r, scr_w_r, scr_h_r;
  logic [SPB_W-1:0]     spb_r;
  logic [PITCH_W-1:0]   pitch_r;
  logic                 center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= DIM_REG_W'(RST_SOURCE_WIDTH);
      src_h_r  <= DIM_REG_W'(RST_SOURCE_HEIGHT);
      tgt_h_r  <= DIM_REG_W'(RST_TARGET_HEIGHT);
      spb_r    <= SPB_W'(RST_SOURCE_PIXEL_BYTES);
      scr_w_r  <= DIM_REG_W'(RST_SCREEN_WIDTH);
      scr_h_r  <= DIM_REG_W'(RST_SCREEN_HEIGHT);
      pitch_r  <= PITCH_W'(RST_SCREEN_PITCH);
      center_r <= 1'(RST_CENTER_MODE);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SOURCE_WIDTH:       src_w_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_SOURCE_HEIGHT:      src_h_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_TARGET_HEIGHT:      tgt_h_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_SOURCE_PIXEL_BYTES: spb_r    <= cfg_wdata[SPB_W-1:0];
        CFG_SCREEN_WIDTH:       scr_w_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_SCREEN_HEIGHT:      scr_h_r  <= cfg_wdata[DIM_REG_W-1:0];
        CFG_SCREEN_PITCH:       pitch_r  <= cfg_wdata[PITCH_W-1:0];
        CFG_CENTER_MODE:        center_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // dimensions saturated to 1..MAX_DIMENSION
  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    if (v == '0) begin
      return DW'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      return DW'(MAX_DIMENSION);
    end else begin
      return DW'(v);
    end
  endfunction

  logic [DW-1:0] sw_d, sh_d, th_d, fw_d, fh_d;

  assign sw_d = clamp_dim(src_w_r);
  assign sh_d = clamp_dim(src_h_r);
  assign th_d = clamp_dim(tgt_h_r);
  assign fw_d = clamp_dim(scr_w_r);
  assign fh_d = clamp_dim(scr_h_r);

  logic [SWW-1:0]         scaled_w;
  logic signed [OXW-1:0]  ox;
  logic signed [OYW-1:0]  oy;
  logic signed [DSW-1:0]  limit;

  nnb_scale_calc #(
    .DW   (DW),
    .LIMW (DSW)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .recalc   (cfg_we),
    .sw       (sw_d),
    .sh       (sh_d),
    .th       (th_d),
    .fw       (fw_d),
    .fh       (fh_d),
    .pitch    (pitch_r),
    .center   (center_r),
    .busy     (busy),
    .scaled_w (scaled_w),
    .ox       (ox),
    .oy       (oy),
    .limit    (limit)
  );

  // entry stage
  logic                  in_acc;
  logic [PW-1:0]         dvd_col_c, dvd_row_c;
  logic signed [RPW-1:0] row_plus_c;
  logic signed [JXW-1:0] jx_c;

  logic                  s_vld_r;
  logic [PW-1:0]         s_dvd_col_r, s_dvd_row_r;
  logic [TW-1:0]         s_tag_r;

  assign in_acc     = start && !busy;
  assign dvd_col_c  = in_dest_column * sw_d;
  assign dvd_row_c  = in_scan_index * sh_d;
  // destination row is target_height - 1 - k, plus the vertical origin
  assign row_plus_c = $signed(RPW'(th_d)) - $signed(RPW'(in_scan_index))
                      - RPW'(1) + RPW'(oy);
  assign jx_c       = $signed(JXW'(in_dest_column)) + JXW'(ox);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s_dvd_col_r <= dvd_col_c;
    s_dvd_row_r <= dvd_row_c;
    s_tag_r     <= {row_plus_c, jx_c};
  end

  // divider cell chain, one quotient bit per cell
  logic          c_vld     [PW+1];
  logic [RW-1:0] c_rem_col [PW+1];
  logic [PW-1:0] c_dq_col  [PW+1];
  logic [RW-1:0] c_rem_row [PW+1];
  logic [PW-1:0] c_dq_row  [PW+1];
  logic [TW-1:0] c_tag     [PW+1];
  logic [RW-1:0] div_col, div_row;

  assign div_col      = RW'(scaled_w);
  assign div_row      = RW'(th_d);
  assign c_vld[0]     = s_vld_r;
  assign c_rem_col[0] = '0;
  assign c_dq_col[0]  = s_dvd_col_r;
  assign c_rem_row[0] = '0;
  assign c_dq_row[0]  = s_dvd_row_r;
  assign c_tag[0]     = s_tag_r;

  for (genvar i = 0; i < PW; i++) begin : g_cell
    nnb_div_cell #(
      .DVW (PW),
      .RW  (RW),
      .TW  (TW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .div_col     (div_col),
      .div_row     (div_row),
      .in_vld      (c_vld[i]),
      .in_rem_col  (c_rem_col[i]),
      .in_dq_col   (c_dq_col[i]),
      .in_rem_row  (c_rem_row[i]),
      .in_dq_row   (c_dq_row[i]),
      .in_tag      (c_tag[i]),
      .out_vld     (c_vld[i+1]),
      .out_rem_col (c_rem_col[i+1]),
      .out_dq_col  (c_dq_col[i+1]),
      .out_rem_row (c_rem_row[i+1]),
      .out_dq_row  (c_dq_row[i+1]),
      .out_tag     (c_tag[i+1])
    );
  end

  // first output stage: row times width, destination row times screen width
  logic [PW-1:0]         col_q;
  logic [PW+DW-1:0]      row_prod;
  logic signed [RPW-1:0] e_row_plus;
  logic signed [JXW-1:0] e_jx;
  logic signed [MPW-1:0] dst_prod;
  logic [SRC_OFF_W-1:0]  src_sum_nxt;
  logic signed [DSW-1:0] dst_nxt;

  logic                  p1_vld_r;
  logic [SRC_OFF_W-1:0]  p1_src_sum_r;
  logic signed [DSW-1:0] p1_dst_r;

  // zero scaled width takes source column 0
  assign col_q       = (scaled_w == '0) ? '0 : c_dq_col[PW];
  assign row_prod    = c_dq_row[PW] * sw_d;
  assign src_sum_nxt = SRC_OFF_W'(row_prod) + SRC_OFF_W'(col_q);
  assign e_row_plus  = $signed(c_tag[PW][TW-1 -: RPW]);
  assign e_jx        = $signed(c_tag[PW][JXW-1:0]);
  assign dst_prod    = e_row_plus * $signed({1'b0, fw_d});
  assign dst_nxt     = DSW'(dst_prod) + DSW'(e_jx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= c_vld[PW];
    end
  end

  always_ff @(posedge clk) begin
    p1_src_sum_r <= src_sum_nxt;
    p1_dst_r     <= dst_nxt;
  end

  // second output stage: pixel size, byte scaling and visibility
  logic [SRC_OFF_W+SPB_W-1:0] src_mul;
  logic signed [DSW-1:0]      dst4;
  logic                       on_nxt;

  logic                       out_vld_r;
  logic [SRC_OFF_W-1:0]       out_src_r;
  logic [DST_OFF_W-1:0]       out_dst_r;
  logic                       out_on_r;

  assign src_mul = p1_src_sum_r * spb_r;
  assign dst4    = p1_dst_r <<< 2;
  assign on_nxt  = !dst4[DSW-1] && (dst4 < limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_src_r <= src_mul[SRC_OFF_W-1:0];
    out_dst_r <= dst4[DST_OFF_W-1:0];
    out_on_r  <= on_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_source_offset = out_src_r;
  assign out_dest_offset   = $signed(out_dst_r);
  assign out_on_screen     = out_on_r;

`ifndef NO_ASSERTIONS
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("accepted word did not produce a result on time");

  a_no_orphan : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result strobe without a matching accepted word");

  a_cfg_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("register write did not start a recompute");
`endif

endmodule
